/* rtl/slfr_pkg.sv */
// ----------------------------------------------------------------------------
// slfr_pkg
// Types and constants shared by the sync/length frame receiver files.
// ----------------------------------------------------------------------------
package slfr_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NAME     = 2'd3;

    // configuration reset values
    localparam logic [7:0]  RST_SYNC_FIRST  = 8'd170;
    localparam logic [7:0]  RST_SYNC_SECOND = 8'd85;
    localparam logic [31:0] RST_MAX_PAYLOAD = 32'd1048576;
    localparam logic [7:0]  RST_MAX_NAME    = 8'd32;

    // length field: four bytes, little endian
    localparam int unsigned LEN_BYTES = 4;
    localparam int unsigned LEN_IDX_W = $clog2(LEN_BYTES);
    localparam logic [LEN_IDX_W-1:0] LEN_LAST = LEN_IDX_W'(LEN_BYTES - 1);

    // byte class codes
    localparam logic [1:0] CLS_HEADER  = 2'd0;
    localparam logic [1:0] CLS_NAME    = 2'd1;
    localparam logic [1:0] CLS_PAYLOAD = 2'd2;

    typedef enum logic [6:0] {
        PH_SYNC1 = 7'b0000001,
        PH_SYNC2 = 7'b0000010,
        PH_LEN   = 7'b0000100,
        PH_CHAN  = 7'b0001000,
        PH_NLEN  = 7'b0010000,
        PH_NAME  = 7'b0100000,
        PH_DATA  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [31:0] max_payload_length;
        logic [7:0]  max_name_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  byte_class;
        logic        frame_open;
        logic        frame_done;
        logic        length_error;
        logic [3:0]  channel_out;
        logic [31:0] payload_length;
        logic [31:0] frame_number;
    } t_result;

endpackage

/* rtl/slfr_rx_if.sv */
// ----------------------------------------------------------------------------
// slfr_rx_if
// Received byte channel: valid/ready handshake with one byte per item.
// ----------------------------------------------------------------------------
interface slfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/slfr_res_if.sv */
// ----------------------------------------------------------------------------
// slfr_res_if
// Result channel: valid/ready handshake with the parsed byte and frame status.
// ----------------------------------------------------------------------------
interface slfr_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  byte_class;
    logic        frame_open;
    logic        frame_done;
    logic        length_error;
    logic [3:0]  channel_out;
    logic [31:0] payload_length;
    logic [31:0] frame_number;

    modport source (
        output valid, output out_byte, output byte_class, output frame_open,
        output frame_done, output length_error, output channel_out,
        output payload_length, output frame_number, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_class, input frame_open,
        input frame_done, input length_error, input channel_out,
        input payload_length, input frame_number, output ready
    );
endinterface

/* rtl/slfr_cfg_if.sv */
// ----------------------------------------------------------------------------
// slfr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface slfr_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [slfr_pkg::CFG_IDX_W-1:0]      index;
    logic [slfr_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/slfr_parser.sv */
// ----------------------------------------------------------------------------
// slfr_parser
// Frame parse state machine: one byte per step, one result per byte.
// ----------------------------------------------------------------------------
module slfr_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slfr_pkg::t_cfg    i_cfg,
    input  logic              i_step,
    input  logic [7:0]        i_rx_byte,
    output slfr_pkg::t_result o_result
);

    slfr_pkg::t_phase                   r_phase, n_phase;
    logic [slfr_pkg::LEN_IDX_W-1:0]     r_len_idx, n_len_idx;
    logic [31:0]                        r_len_accum, n_len_accum;
    logic [3:0]                         r_channel, n_channel;
    logic [7:0]                         r_name_len, n_name_len;
    logic [7:0]                         r_name_idx, n_name_idx;
    logic [31:0]                        r_pay_count, n_pay_count;
    logic [31:0]                        r_frame_cnt, n_frame_cnt;

    logic [1:0]  cls;
    logic        open, done, lerr;
    logic [31:0] fnum;
    logic [31:0] plen;
    logic [31:0] byte_lane;
    logic [7:0]  name_clamp;

    always_comb begin
        n_phase     = r_phase;
        n_len_idx   = r_len_idx;
        n_len_accum = r_len_accum;
        n_channel   = r_channel;
        n_name_len  = r_name_len;
        n_name_idx  = r_name_idx;
        n_pay_count = r_pay_count;
        n_frame_cnt = r_frame_cnt;
        cls         = slfr_pkg::CLS_HEADER;
        open        = 1'b0;
        done        = 1'b0;
        lerr        = 1'b0;
        fnum        = 32'd0;
        name_clamp  = (i_rx_byte > i_cfg.max_name_length) ?
                      i_cfg.max_name_length : i_rx_byte;

        // place the length byte in its lane
        case (r_len_idx)
            2'd0:    byte_lane = {24'd0, i_rx_byte};
            2'd1:    byte_lane = {16'd0, i_rx_byte, 8'd0};
            2'd2:    byte_lane = {8'd0, i_rx_byte, 16'd0};
            default: byte_lane = {i_rx_byte, 24'd0};
        endcase

        case (r_phase)
            slfr_pkg::PH_SYNC2: begin
                if (i_rx_byte == i_cfg.sync_second) begin
                    n_phase   = slfr_pkg::PH_LEN;
                    n_len_idx = '0;
                end else if (i_rx_byte != i_cfg.sync_first) begin
                    n_phase = slfr_pkg::PH_SYNC1;
                end
            end
            slfr_pkg::PH_LEN: begin
                n_len_accum = (r_len_idx == '0) ? byte_lane : (r_len_accum | byte_lane);
                n_len_idx   = r_len_idx + 1'b1;
                if (r_len_idx == slfr_pkg::LEN_LAST) begin
                    if (n_len_accum == 32'd0 || n_len_accum > i_cfg.max_payload_length) begin
                        lerr = 1'b1;
                    end else begin
                        n_phase = slfr_pkg::PH_CHAN;
                    end
                end
            end
            slfr_pkg::PH_CHAN: begin
                n_channel = i_rx_byte[3:0];
                n_phase   = slfr_pkg::PH_NLEN;
            end
            slfr_pkg::PH_NLEN: begin
                n_name_len = name_clamp;
                n_name_idx = 8'd0;
                if (name_clamp == 8'd0) begin
                    open = 1'b1;
                end else begin
                    n_phase = slfr_pkg::PH_NAME;
                end
            end
            slfr_pkg::PH_NAME: begin
                cls        = slfr_pkg::CLS_NAME;
                n_name_idx = r_name_idx + 8'd1;
                if (n_name_idx >= r_name_len) begin
                    open = 1'b1;
                end
            end
            slfr_pkg::PH_DATA: begin
                cls         = slfr_pkg::CLS_PAYLOAD;
                fnum        = r_frame_cnt - 32'd1;
                n_pay_count = r_pay_count + 32'd1;
                if (n_pay_count >= r_len_accum) begin
                    done = 1'b1;
                end
            end
            default: begin
                n_phase = (i_rx_byte == i_cfg.sync_first) ?
                          slfr_pkg::PH_SYNC2 : slfr_pkg::PH_SYNC1;
            end
        endcase

        if (open) begin
            fnum        = r_frame_cnt;
            n_frame_cnt = r_frame_cnt + 32'd1;
            n_pay_count = 32'd0;
            n_phase     = slfr_pkg::PH_DATA;
        end

        plen = n_len_accum;

        // drop the frame state and restart the hunt
        if (lerr || done) begin
            n_phase     = slfr_pkg::PH_SYNC1;
            n_len_idx   = '0;
            n_len_accum = 32'd0;
            n_name_len  = 8'd0;
            n_name_idx  = 8'd0;
            n_pay_count = 32'd0;
        end

        o_result.out_byte       = (cls != slfr_pkg::CLS_HEADER) ? i_rx_byte : 8'd0;
        o_result.byte_class     = cls;
        o_result.frame_open     = open;
        o_result.frame_done     = done;
        o_result.length_error   = lerr;
        o_result.channel_out    = n_channel;
        o_result.payload_length = plen;
        o_result.frame_number   = fnum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= slfr_pkg::PH_SYNC1;
            r_len_idx   <= '0;
            r_len_accum <= 32'd0;
            r_channel   <= 4'd0;
            r_name_len  <= 8'd0;
            r_name_idx  <= 8'd0;
            r_pay_count <= 32'd0;
            r_frame_cnt <= 32'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_len_idx   <= n_len_idx;
            r_len_accum <= n_len_accum;
            r_channel   <= n_channel;
            r_name_len  <= n_name_len;
            r_name_idx  <= n_name_idx;
            r_pay_count <= n_pay_count;
            r_frame_cnt <= n_frame_cnt;
        end
    end

endmodule

/* rtl/sync_length_frame_receiver_top.sv */
// Receives one byte per item, hunts for the two sync bytes, reads a 4-byte
// little-endian length, a channel byte and a name-length byte, then passes
// the name and payload bytes out tagged by class. Every accepted byte gives
// exactly one result item, registered and shown in the cycle after acceptance.
// The block takes one item per cycle unless the result channel stalls: the rx
// channel is ready whenever the result register is empty or its item is being
// taken in the same cycle, so throughput is set only by the consumer of the
// result channel. The whole parse step is a single pass of compares and 32-bit
// counters between the state registers. Configuration writes are always
// accepted (ready is high) and take effect on the next byte.
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_top
// Sync/length prefixed frame receiver: config registers, parser, result
// register.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slfr_cfg_if.sink   i_cfg,
    slfr_rx_if.sink    i_rx,
    slfr_res_if.source o_res
);

    slfr_pkg::t_cfg    r_cfg;
    slfr_pkg::t_result step_result;
    slfr_pkg::t_result r_result;
    logic              r_out_valid;
    logic              rx_ready;
    logic              step;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first         <= slfr_pkg::RST_SYNC_FIRST;
            r_cfg.sync_second        <= slfr_pkg::RST_SYNC_SECOND;
            r_cfg.max_payload_length <= slfr_pkg::RST_MAX_PAYLOAD;
            r_cfg.max_name_length    <= slfr_pkg::RST_MAX_NAME;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                slfr_pkg::CFG_SYNC_FIRST:  r_cfg.sync_first         <= i_cfg.data[7:0];
                slfr_pkg::CFG_SYNC_SECOND: r_cfg.sync_second        <= i_cfg.data[7:0];
                slfr_pkg::CFG_MAX_PAYLOAD: r_cfg.max_payload_length <= i_cfg.data[31:0];
                slfr_pkg::CFG_MAX_NAME:    r_cfg.max_name_length    <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // accept while the result register is free or draining
    assign rx_ready   = !r_out_valid || o_res.ready;
    assign i_rx.ready = rx_ready;
    assign step       = i_rx.valid && rx_ready;

    slfr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_step    (step),
        .i_rx_byte (i_rx.rx_byte),
        .o_result  (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rx_ready) begin
            r_out_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= step_result;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.out_byte       = r_result.out_byte;
    assign o_res.byte_class     = r_result.byte_class;
    assign o_res.frame_open     = r_result.frame_open;
    assign o_res.frame_done     = r_result.frame_done;
    assign o_res.length_error   = r_result.length_error;
    assign o_res.channel_out    = r_result.channel_out;
    assign o_res.payload_length = r_result.payload_length;
    assign o_res.frame_number   = r_result.frame_number;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sync_length_frame_receiver_top. A short script walks
// the header corner cases, then randomized frames, broken frames and noise run
// under several register settings. Every result item is checked field by
// field against a shadow parser kept in the bench, or against the given result for scripted rows.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PAYLOAD_CAP = 24;
    localparam int unsigned PHASE_ITEMS = 180;

    typedef enum logic [1:0] {ROW_BYTE, ROW_KNOWN, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [1:0]        idx;
        logic [31:0]       value;
        slfr_pkg::t_result want;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    slfr_cfg_if cfg_ch ();
    slfr_rx_if  rx_ch ();
    slfr_res_if res_ch ();

    sync_length_frame_receiver_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    // shadow parser state and register copy
    slfr_pkg::t_cfg    cur_cfg;
    slfr_pkg::t_phase  ph;
    logic [1:0]        len_idx;
    logic [31:0]       len_acc;
    logic [3:0]        chan;
    logic [7:0]        nlen;
    logic [7:0]        nidx;
    logic [31:0]       pcount;
    logic [31:0]       fcount;

    slfr_pkg::t_result due_results[$];
    slfr_pkg::t_result seen;
    slfr_pkg::t_result oldest;
    t_script_row       script_rows[$];
    slfr_pkg::t_cfg    setting[5];
    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned src_pct = 24;
    int unsigned snk_pct = 85;
    int unsigned stuck_cycles = 0;

    always #2 i_clk = ~i_clk;

    function automatic void restart_hunt();
        ph = slfr_pkg::PH_SYNC1;
        len_idx = '0;
        len_acc = '0;
        nlen = '0;
        nidx = '0;
        pcount = '0;
    endfunction

    function automatic slfr_pkg::t_result parse_byte(input logic [7:0] b);
        slfr_pkg::t_result r;
        logic    opened;
        logic    dropped;
        r = '0;
        opened = 1'b0;
        dropped = 1'b0;
        case (ph)
            slfr_pkg::PH_SYNC2: begin
                if (b == cur_cfg.sync_second) begin
                    ph = slfr_pkg::PH_LEN;
                    len_idx = '0;
                end else if (b != cur_cfg.sync_first) begin
                    ph = slfr_pkg::PH_SYNC1;
                end
            end
            slfr_pkg::PH_LEN: begin
                if (len_idx == 2'd0) len_acc = '0;
                len_acc = len_acc | (32'(b) << (8 * len_idx));
                len_idx = len_idx + 2'd1;
                if (len_idx == 2'd0) begin
                    if (len_acc == '0 || len_acc > cur_cfg.max_payload_length) dropped = 1'b1;
                    else ph = slfr_pkg::PH_CHAN;
                end
            end
            slfr_pkg::PH_CHAN: begin
                chan = b[3:0];
                ph = slfr_pkg::PH_NLEN;
            end
            slfr_pkg::PH_NLEN: begin
                nlen = (b > cur_cfg.max_name_length) ? cur_cfg.max_name_length : b;
                nidx = '0;
                if (nlen == '0) opened = 1'b1;
                else ph = slfr_pkg::PH_NAME;
            end
            slfr_pkg::PH_NAME: begin
                r.byte_class = slfr_pkg::CLS_NAME;
                r.out_byte = b;
                nidx = nidx + 8'd1;
                if (nidx >= nlen) opened = 1'b1;
            end
            slfr_pkg::PH_DATA: begin
                r.byte_class = slfr_pkg::CLS_PAYLOAD;
                r.out_byte = b;
                r.frame_number = fcount - 32'd1;
                pcount = pcount + 32'd1;
                if (pcount >= len_acc) r.frame_done = 1'b1;
            end
            default: begin
                ph = (b == cur_cfg.sync_first) ? slfr_pkg::PH_SYNC2 : slfr_pkg::PH_SYNC1;
            end
        endcase
        if (opened) begin
            r.frame_open = 1'b1;
            r.frame_number = fcount;
            fcount = fcount + 32'd1;
            pcount = '0;
            ph = slfr_pkg::PH_DATA;
        end
        r.length_error = dropped;
        r.channel_out = chan;
        r.payload_length = len_acc;
        if (dropped || r.frame_done) restart_hunt();
        return r;
    endfunction

    function automatic slfr_pkg::t_result res_of(input logic [7:0] ob, input logic [1:0] cls,
                                                 input logic op, input logic dn,
                                                 input logic le, input logic [3:0] ch,
                                                 input logic [31:0] pl,
                                                 input logic [31:0] fn);
        return {ob, cls, op, dn, le, ch, pl, fn};
    endfunction

    function automatic t_script_row script_row(input t_row_kind k, input logic [1:0] i,
                                               input logic [31:0] v,
                                               input slfr_pkg::t_result w);
        return {k, i, v, w};
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        if (mismatches < 40) begin
            $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        end
        mismatches++;
    endtask

    task automatic push_byte(input logic [7:0] b, input bit known = 1'b0,
                             input slfr_pkg::t_result want = '0);
        slfr_pkg::t_result r;
        src_pct = (bytes_sent < 330) ? 24 : (bytes_sent < 630) ? 85 : 0;
        snk_pct = (bytes_sent < 330) ? 85 : (bytes_sent < 630) ? 24 : 0;
        @(negedge i_clk);
        while ($urandom_range(99) < src_pct) begin
            rx_ch.valid <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom);
            @(negedge i_clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        r = parse_byte(b);
        due_results.push_back(known ? want : r);
        bytes_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            slfr_pkg::CFG_SYNC_FIRST:  cur_cfg.sync_first = v[7:0];
            slfr_pkg::CFG_SYNC_SECOND: cur_cfg.sync_second = v[7:0];
            slfr_pkg::CFG_MAX_PAYLOAD: cur_cfg.max_payload_length = v;
            default:                   cur_cfg.max_name_length = v[7:0];
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // build one frame, optionally cut short and corrupted
    task automatic send_frame(input bit broken);
        logic [7:0]  q[$];
        logic [31:0] flen;
        int unsigned cap;
        int unsigned name_n;
        int unsigned cut;
        cap = (cur_cfg.max_payload_length == '0) ? 1 :
              (cur_cfg.max_payload_length > PAYLOAD_CAP) ? PAYLOAD_CAP :
              int'(cur_cfg.max_payload_length);
        case ($urandom_range(9))
            0: flen = '0;
            1: flen = (cur_cfg.max_payload_length == '1) ? 32'd0 :
                      cur_cfg.max_payload_length + 32'd1;
            2: flen = (cur_cfg.max_payload_length == '1) ? 32'(cap) : $urandom;
            default: flen = $urandom_range(cap, 1);
        endcase
        if ($urandom_range(7) == 0) q.push_back(cur_cfg.sync_first);
        q.push_back(cur_cfg.sync_first);
        q.push_back(cur_cfg.sync_second);
        for (int i = 0; i < 4; i++) q.push_back(flen[8*i +: 8]);
        q.push_back(8'($urandom));
        name_n = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(4);
        q.push_back(8'(name_n));
        repeat (name_n) q.push_back(8'($urandom));
        repeat ((flen > PAYLOAD_CAP) ? PAYLOAD_CAP : flen) q.push_back(8'($urandom));
        if (broken) begin
            cut = $urandom_range(q.size() - 1);
            while (q.size() > cut) q.delete(q.size() - 1);
            if (cut != 0 && $urandom_range(1) == 1) q[$urandom_range(cut - 1)] = 8'($urandom);
        end
        foreach (q[i]) push_byte(q[i]);
    endtask

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= snk_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen = {res_ch.out_byte, res_ch.byte_class, res_ch.frame_open, res_ch.frame_done,
                    res_ch.length_error, res_ch.channel_out, res_ch.payload_length,
                    res_ch.frame_number};
            if (due_results.size() == 0) begin
                report("result with nothing due", 32'(seen.out_byte), 32'd0);
            end else begin
                oldest = due_results.pop_front();
                if (seen.out_byte !== oldest.out_byte)
                    report("out_byte", 32'(seen.out_byte), 32'(oldest.out_byte));
                if (seen.byte_class !== oldest.byte_class)
                    report("byte_class", 32'(seen.byte_class), 32'(oldest.byte_class));
                if (seen.frame_open !== oldest.frame_open)
                    report("frame_open", 32'(seen.frame_open), 32'(oldest.frame_open));
                if (seen.frame_done !== oldest.frame_done)
                    report("frame_done", 32'(seen.frame_done), 32'(oldest.frame_done));
                if (seen.length_error !== oldest.length_error)
                    report("length_error", 32'(seen.length_error),
                           32'(oldest.length_error));
                if (seen.channel_out !== oldest.channel_out)
                    report("channel_out", 32'(seen.channel_out), 32'(oldest.channel_out));
                if (seen.payload_length !== oldest.payload_length)
                    report("payload_length", seen.payload_length, oldest.payload_length);
                if (seen.frame_number !== oldest.frame_number)
                    report("frame_number", seen.frame_number, oldest.frame_number);
            end
        end
    end

    // stop if no channel moves an item for too long
    always @(posedge i_clk) begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles = stuck_cycles + 1;
        end
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("sync_length_frame_receiver_top regression: fail");
            $finish;
        end
    end

    initial begin
        int unsigned goal;
        int unsigned tries;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = slfr_pkg::CFG_SYNC_FIRST;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        cur_cfg = {slfr_pkg::RST_SYNC_FIRST, slfr_pkg::RST_SYNC_SECOND,
                   slfr_pkg::RST_MAX_PAYLOAD, slfr_pkg::RST_MAX_NAME};
        restart_hunt();
        chan = '0;
        fcount = '0;

        setting[0] = {8'h00, 8'hFF, 32'd16, 8'd0};
        setting[1] = {8'hFF, 8'h00, 32'd40, 8'd255};
        // equal sync values with a zero length limit: every frame drops
        setting[2] = {8'h5A, 8'h5A, 32'd0, 8'd8};
        setting[3] = {8'($urandom), 8'($urandom), 32'd24, 8'd3};
        setting[4] = {8'hC3, 8'h3C, 32'hFFFF_FFFF, 8'd16};

        // reset settings: repeated first sync, zero name length, one-byte frame
        script_rows.push_back(script_row(ROW_KNOWN, 2'd0, 32'hAA,
            res_of(8'h00, slfr_pkg::CLS_HEADER, 1'b0, 1'b0, 1'b0, 4'h0, 32'd0, 32'd0)));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'hAA, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h55, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h01, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h00, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h00, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h00, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'hFF, '0));
        script_rows.push_back(script_row(ROW_KNOWN, 2'd0, 32'h00,
            res_of(8'h00, slfr_pkg::CLS_HEADER, 1'b1, 1'b0, 1'b0, 4'hF, 32'd1, 32'd0)));
        script_rows.push_back(script_row(ROW_KNOWN, 2'd0, 32'hFF,
            res_of(8'hFF, slfr_pkg::CLS_PAYLOAD, 1'b0, 1'b1, 1'b0, 4'hF, 32'd1, 32'd0)));
        // length one above the limit; channel holds over the dropped frame
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'hAA, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h55, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h01, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h00, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h10, '0));
        script_rows.push_back(script_row(ROW_KNOWN, 2'd0, 32'h00,
            res_of(8'h00, slfr_pkg::CLS_HEADER, 1'b0, 1'b0, 1'b1, 4'hF, 32'h0010_0001,
                   32'd0)));
        // equal sync values, name clamped to one byte, rest taken as payload
        script_rows.push_back(script_row(ROW_REG, slfr_pkg::CFG_SYNC_FIRST, 32'h3C, '0));
        script_rows.push_back(script_row(ROW_REG, slfr_pkg::CFG_SYNC_SECOND, 32'h3C, '0));
        script_rows.push_back(script_row(ROW_REG, slfr_pkg::CFG_MAX_NAME, 32'd1, '0));
        script_rows.push_back(script_row(ROW_REG, slfr_pkg::CFG_MAX_PAYLOAD, 32'hFFFF_FFFF,
                                         '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h3C, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h3C, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h02, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h00, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h00, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h00, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h03, '0));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h05, '0));
        script_rows.push_back(script_row(ROW_KNOWN, 2'd0, 32'h41,
            res_of(8'h41, slfr_pkg::CLS_NAME, 1'b1, 1'b0, 1'b0, 4'h3, 32'd2, 32'd1)));
        script_rows.push_back(script_row(ROW_BYTE, 2'd0, 32'h42, '0));
        script_rows.push_back(script_row(ROW_KNOWN, 2'd0, 32'h43,
            res_of(8'h43, slfr_pkg::CLS_PAYLOAD, 1'b0, 1'b1, 1'b0, 4'h3, 32'd2, 32'd1)));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script_rows[k]) begin
            if (script_rows[k].kind == ROW_REG) begin
                drain_results();
                write_reg(script_rows[k].idx, script_rows[k].value);
            end else begin
                push_byte(script_rows[k].value[7:0], script_rows[k].kind == ROW_KNOWN,
                          script_rows[k].want);
            end
        end

        foreach (setting[p]) begin
            drain_results();
            write_reg(slfr_pkg::CFG_SYNC_FIRST, 32'(setting[p].sync_first));
            write_reg(slfr_pkg::CFG_SYNC_SECOND, 32'(setting[p].sync_second));
            write_reg(slfr_pkg::CFG_MAX_PAYLOAD, setting[p].max_payload_length);
            write_reg(slfr_pkg::CFG_MAX_NAME, 32'(setting[p].max_name_length));
            goal = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < goal) begin
                case ($urandom_range(9))
                    0: repeat ($urandom_range(6, 1)) push_byte(8'($urandom));
                    // a cut-off length field could open a huge frame without a limit
                    1: send_frame(cur_cfg.max_payload_length != '1);
                    default: send_frame(1'b0);
                endcase
            end
            // finish any open frame so the next setting starts from the hunt
            tries = 0;
            while (ph != slfr_pkg::PH_SYNC1 && tries < 400) begin
                push_byte(8'($urandom));
                tries++;
            end
        end

        // all-ones length under the widest limit; the frame stays open
        push_byte(cur_cfg.sync_first);
        push_byte(cur_cfg.sync_second);
        repeat (4) push_byte(8'hFF);
        push_byte(8'($urandom));
        push_byte(8'h00);
        repeat (6) push_byte(8'($urandom));

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("sync_length_frame_receiver_top regression: pass");
        end else begin
            $display("sync_length_frame_receiver_top regression: fail");
        end
        $finish;
    end

endmodule
